// ===== design/tpf_pkg.sv =====
// Shared types and constants of the timestamped packet FIFO.
package tpf_pkg;

   localparam int LEN_W       = 7;
   localparam int STAMP_W     = 32;
   localparam int BYTE_W      = 8;
   localparam int CMD_W       = 3;
   localparam int STATUS_W    = 2;
   localparam int STAMP_BYTES = 4;

   // Command codes of an input item; the two spare codes have no member.
   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_HDR  = 3'd0,
      CMD_PUSH_DATA = 3'd1,
      CMD_POP       = 3'd2,
      CMD_PEEK      = 3'd3,
      CMD_DISCARD   = 3'd4,
      CMD_CLEAR     = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK     = 2'd0,
      STS_EMPTY  = 2'd1,
      STS_REJECT = 2'd2,
      STS_ACCEPT = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_HDR_WR,
      S_HDR_RD,
      S_PAY,
      S_RESP,
      S_FREE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;
      logic       hdr_accept;
      logic       hdr_reject;
      logic       data_fill;
      logic       data_drop;
      logic       clear_all;
      logic       rd_start;
      logic       hdr_wr;
      logic       hdr_rd;
      logic       pay_start;
      logic       pay_next;
      logic       free_head;
      logic       load_res;
      status_type res_status;
      logic       res_stamp;
   } dp_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      cmd_type cmd;
      logic    fill_nz;
      logic    drop_nz;
      logic    hdr_fits;
      logic    pkts_nz;
      logic    hdr_wr_last;
      logic    hdr_rd_last;
      logic    copy_zero;
      logic    pay_last;
   } dp_status_type;

endpackage

// ===== design/tpf_req_if.sv =====
// Request channel of the timestamped packet FIFO.
interface tpf_req_if;
   import tpf_pkg::*;

   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [STAMP_W-1:0]  stamp;
   logic [LEN_W-1:0]    packet_length;
   logic [BYTE_W-1:0]   data_byte;
   logic [LEN_W-1:0]    read_limit;

   modport source (output valid, command, stamp, packet_length, data_byte, read_limit,
                   input ready);
   modport sink   (input valid, command, stamp, packet_length, data_byte, read_limit,
                   output ready);
endinterface

// ===== design/tpf_rsp_if.sv =====
// Response channel of the timestamped packet FIFO.
interface tpf_rsp_if;
   import tpf_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [STAMP_W-1:0]  packet_stamp;
   logic [BYTE_W-1:0]   payload_byte;
   logic                byte_valid;
   logic                is_last;
   logic [LEN_W-1:0]    copied_length;

   modport source (output valid, status, packet_stamp, payload_byte, byte_valid, is_last,
                   copied_length, input ready);
   modport sink   (input valid, status, packet_stamp, payload_byte, byte_valid, is_last,
                   copied_length, output ready);
endinterface

// ===== design/timestamped_packet_fifo.sv =====
// Top level of the timestamped packet FIFO: controller, datapath and checks.
//
// Packets are stored in a ring of CAPACITY_BYTES bytes, each taking HEADER_BYTES of header
// plus its payload, and the block handles one request item at a time through a byte store
// with one write port and one registered read port. A push header writes its HEADER_BYTES
// header slots before its response item; a data byte, clear or rejected header goes straight
// to its response, and a discard reads the length slot, responds, then releases the packet. A
// pop or peek reads min(HEADER_BYTES, 5) header slots and then delivers one payload byte per
// cycle while the response side is ready; a pop then releases the packet. A new request is
// taken only once the previous one has delivered its last response item.
module timestamped_packet_fifo #(
   parameter int CAPACITY_BYTES = 2048,
   parameter int HEADER_BYTES   = 8,
   parameter int MAX_PAYLOAD    = 64
) (
   input logic         clock,
   input logic         reset,
   tpf_req_if.sink     req_chan,
   tpf_rsp_if.source   rsp_chan
);
   import tpf_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // Sequencer.
   tpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   // Store and response datapath.
   tpf_dp #(
      .CAPACITY_BYTES (CAPACITY_BYTES),
      .HEADER_BYTES   (HEADER_BYTES),
      .MAX_PAYLOAD    (MAX_PAYLOAD)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .dp_cmd            (dp_cmd),
      .dp_status         (dp_status),
      .req_command       (req_chan.command),
      .req_stamp         (req_chan.stamp),
      .req_packet_length (req_chan.packet_length),
      .req_data_byte     (req_chan.data_byte),
      .req_read_limit    (req_chan.read_limit),
      .rsp_status        (rsp_chan.status),
      .rsp_packet_stamp  (rsp_chan.packet_stamp),
      .rsp_payload_byte  (rsp_chan.payload_byte),
      .rsp_byte_valid    (rsp_chan.byte_valid),
      .rsp_is_last       (rsp_chan.is_last),
      .rsp_copied_length (rsp_chan.copied_length)
   );

   // The block never offers a response while it can take a new request.
   assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("request ready while a response item is pending");

   // An accepted request keeps the block busy in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request taken twice in a row");

   // A payload run continues until its last item.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !rsp_chan.is_last) |=> rsp_chan.valid)
      else $error("payload run broken before its last item");

   // Payload bytes only ever come with an ok status.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.byte_valid) |-> (rsp_chan.status == STS_OK))
      else $error("payload byte with a non-ok status");

endmodule

// ===== design/tpf_ctrl.sv =====
// Controller state machine that sequences each command through the datapath.
module tpf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  tpf_pkg::dp_status_type dp_status,
   output tpf_pkg::dp_cmd_type    dp_cmd
);
   import tpf_pkg::*;

   state_type state_ff, state_in;
   logic      free_pend_ff, free_pend_in;
   logic      frees_head;

   // Pop and discard of a visible packet release it once their results are out.
   assign frees_head = ((dp_status.cmd == CMD_POP) || (dp_status.cmd == CMD_DISCARD)) &&
                       dp_status.pkts_nz;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         free_pend_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_pend_ff <= free_pend_in;
      end
   end

   // Next state.
   always_comb begin
      state_in     = state_ff;
      free_pend_in = free_pend_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            free_pend_in = frees_head;
            case (dp_status.cmd)
               CMD_PUSH_HDR: begin
                  if (!dp_status.fill_nz && dp_status.hdr_fits) state_in = S_HDR_WR;
                  else state_in = S_RESP;
               end
               CMD_POP, CMD_PEEK, CMD_DISCARD: begin
                  if (dp_status.pkts_nz) state_in = S_HDR_RD;
                  else state_in = S_RESP;
               end
               default: state_in = S_RESP;
            endcase
         end
         S_HDR_WR: begin
            if (dp_status.hdr_wr_last) state_in = S_RESP;
         end
         S_HDR_RD: begin
            if (dp_status.hdr_rd_last) begin
               if ((dp_status.cmd == CMD_DISCARD) || dp_status.copy_zero) state_in = S_RESP;
               else state_in = S_PAY;
            end
         end
         S_PAY: begin
            if (rsp_ready && dp_status.pay_last) state_in = free_pend_ff ? S_FREE : S_IDLE;
         end
         S_RESP: begin
            if (rsp_ready) state_in = free_pend_ff ? S_FREE : S_IDLE;
         end
         S_FREE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      dp_cmd            = '0;
      dp_cmd.res_status = STS_OK;
      req_ready         = 1'b0;
      rsp_valid         = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready      = 1'b1;
            dp_cmd.capture = req_valid;
         end
         S_EXEC: begin
            case (dp_status.cmd)
               CMD_PUSH_HDR: begin
                  dp_cmd.load_res = 1'b1;
                  if (dp_status.fill_nz) begin
                     dp_cmd.res_status = STS_REJECT;
                  end else if (dp_status.hdr_fits) begin
                     dp_cmd.hdr_accept = 1'b1;
                     dp_cmd.res_status = STS_ACCEPT;
                  end else begin
                     dp_cmd.hdr_reject = 1'b1;
                     dp_cmd.res_status = STS_REJECT;
                  end
               end
               CMD_PUSH_DATA: begin
                  dp_cmd.load_res = 1'b1;
                  if (dp_status.fill_nz) dp_cmd.data_fill = 1'b1;
                  else if (dp_status.drop_nz) dp_cmd.data_drop = 1'b1;
                  else dp_cmd.res_status = STS_REJECT;
               end
               CMD_POP, CMD_PEEK: begin
                  if (dp_status.pkts_nz) begin
                     dp_cmd.rd_start = 1'b1;
                  end else begin
                     dp_cmd.load_res   = 1'b1;
                     dp_cmd.res_status = STS_EMPTY;
                  end
               end
               CMD_DISCARD: begin
                  dp_cmd.load_res = 1'b1;
                  if (dp_status.pkts_nz) dp_cmd.rd_start = 1'b1;
                  else dp_cmd.res_status = STS_EMPTY;
               end
               CMD_CLEAR: begin
                  dp_cmd.clear_all = 1'b1;
                  dp_cmd.load_res  = 1'b1;
               end
               default: dp_cmd.load_res = 1'b1;
            endcase
         end
         S_HDR_WR: dp_cmd.hdr_wr = 1'b1;
         S_HDR_RD: begin
            dp_cmd.hdr_rd = 1'b1;
            if (dp_status.hdr_rd_last && (dp_status.cmd != CMD_DISCARD)) begin
               if (dp_status.copy_zero) begin
                  dp_cmd.load_res  = 1'b1;
                  dp_cmd.res_stamp = 1'b1;
               end else begin
                  dp_cmd.pay_start = 1'b1;
               end
            end
         end
         S_PAY: begin
            rsp_valid       = 1'b1;
            dp_cmd.pay_next = rsp_ready && !dp_status.pay_last;
         end
         S_RESP: rsp_valid = 1'b1;
         S_FREE: dp_cmd.free_head = 1'b1;
         default: ;
      endcase
   end

endmodule

// ===== design/tpf_dp.sv =====
// Datapath: byte ring, pointers, counters and the response registers.
module tpf_dp #(
   parameter int CAPACITY_BYTES = 2048,
   parameter int HEADER_BYTES   = 8,
   parameter int MAX_PAYLOAD    = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tpf_pkg::dp_cmd_type           dp_cmd,
   output tpf_pkg::dp_status_type        dp_status,
   input  logic [tpf_pkg::CMD_W-1:0]     req_command,
   input  logic [tpf_pkg::STAMP_W-1:0]   req_stamp,
   input  logic [tpf_pkg::LEN_W-1:0]     req_packet_length,
   input  logic [tpf_pkg::BYTE_W-1:0]    req_data_byte,
   input  logic [tpf_pkg::LEN_W-1:0]     req_read_limit,
   output logic [tpf_pkg::STATUS_W-1:0]  rsp_status,
   output logic [tpf_pkg::STAMP_W-1:0]   rsp_packet_stamp,
   output logic [tpf_pkg::BYTE_W-1:0]    rsp_payload_byte,
   output logic                          rsp_byte_valid,
   output logic                          rsp_is_last,
   output logic [tpf_pkg::LEN_W-1:0]     rsp_copied_length
);
   import tpf_pkg::*;

   localparam int AW   = $clog2(CAPACITY_BYTES);
   localparam int UW   = $clog2(CAPACITY_BYTES + 1);
   localparam int PW   = $clog2(CAPACITY_BYTES / HEADER_BYTES + 1);
   localparam int HW   = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
   localparam int NHDR = (HEADER_BYTES < STAMP_BYTES + 1) ? HEADER_BYTES : STAMP_BYTES + 1;

   // Byte store.
   logic [BYTE_W-1:0] mem_ff [CAPACITY_BYTES];

   cmd_type            cmd_ff, cmd_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;
   logic [LEN_W-1:0]   plen_ff, plen_in;
   logic [BYTE_W-1:0]  dbyte_ff, dbyte_in;
   logic [LEN_W-1:0]   limit_ff, limit_in;
   logic [AW-1:0]      head_ff, head_in;
   logic [AW-1:0]      tail_ff, tail_in;
   logic [UW-1:0]      used_ff, used_in;
   logic [PW-1:0]      pkts_ff, pkts_in;
   logic [LEN_W-1:0]   fill_ff, fill_in;
   logic [LEN_W-1:0]   drop_ff, drop_in;
   logic [AW-1:0]      rd_addr_ff, rd_addr_in;
   logic [BYTE_W-1:0]  rd_data_ff;
   logic [2:0]         rd_idx_ff, rd_idx_in;
   logic [HW-1:0]      wr_idx_ff, wr_idx_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [STAMP_W-1:0] pstamp_ff, pstamp_in;
   logic [LEN_W-1:0]   copy_ff, copy_in;
   logic [LEN_W-1:0]   remain_ff, remain_in;
   status_type         res_status_ff, res_status_in;
   logic               res_stamp_ff, res_stamp_in;
   logic               byte_mode_ff, byte_mode_in;

   logic [UW:0]        need_sum;
   logic               hdr_fits;
   logic [LEN_W-1:0]   rd_len;
   logic [LEN_W-1:0]   len_cur;
   logic [LEN_W-1:0]   copy_cur;
   logic               hdr_rd_last;
   logic [AW-1:0]      pay_base;
   logic [LEN_W-1:0]   total;
   logic [BYTE_W-1:0]  hdr_byte;
   logic               rd_en;
   logic [AW-1:0]      rd_sel;
   logic               wr_en;
   logic [BYTE_W-1:0]  wr_data;

   function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
      ring_inc = (p == AW'(CAPACITY_BYTES - 1)) ? '0 : p + 1'b1;
   endfunction

   // Offsets stay below the capacity, so one subtract folds the sum back.
   function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] p,
                                              input logic [LEN_W-1:0] off);
      logic [AW:0] s;
      s = {1'b0, p} + (AW+1)'(off);
      if (s >= (AW+1)'(CAPACITY_BYTES)) s = s - (AW+1)'(CAPACITY_BYTES);
      ring_add = s[AW-1:0];
   endfunction

   // Admission check, head length and copy length.
   always_comb begin
      need_sum = {1'b0, used_ff} + (UW+1)'(HEADER_BYTES) + (UW+1)'(plen_ff);
      hdr_fits = (plen_ff <= LEN_W'(MAX_PAYLOAD)) &&
                 (need_sum <= (UW+1)'(CAPACITY_BYTES));
      rd_len   = (rd_data_ff > BYTE_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD)
                                                     : rd_data_ff[LEN_W-1:0];
      len_cur  = (rd_idx_ff == 3'd0) ? rd_len : len_ff;
      copy_cur = (limit_ff < len_cur) ? limit_ff : len_cur;
      hdr_rd_last = (cmd_ff == CMD_DISCARD) ? (rd_idx_ff == 3'd0)
                                            : (rd_idx_ff == 3'(NHDR - 1));
      pay_base = ring_add(head_ff, LEN_W'(HEADER_BYTES));
      total    = LEN_W'(HEADER_BYTES) + len_ff;
   end

   // Header byte for the current write slot: length, then stamp from the low byte.
   always_comb begin
      hdr_byte = '0;
      if (wr_idx_ff == '0) hdr_byte = {1'b0, plen_ff};
      for (int k = 1; k <= STAMP_BYTES; k++) begin
         if (int'(wr_idx_ff) == k) hdr_byte = stamp_ff[8*(k-1) +: 8];
      end
   end

   // Memory port selection.
   always_comb begin
      rd_en   = 1'b0;
      rd_sel  = rd_addr_ff;
      if (dp_cmd.rd_start) begin
         rd_en  = 1'b1;
         rd_sel = head_ff;
      end
      if (dp_cmd.hdr_rd && !hdr_rd_last) rd_en = 1'b1;
      if (dp_cmd.pay_start) begin
         rd_en  = 1'b1;
         rd_sel = pay_base;
      end
      if (dp_cmd.pay_next) rd_en = 1'b1;
      rd_addr_in = rd_en ? ring_inc(rd_sel) : rd_addr_ff;
      wr_en   = dp_cmd.hdr_wr || dp_cmd.data_fill;
      wr_data = dp_cmd.hdr_wr ? hdr_byte : dbyte_ff;
   end

   // Next values of the registers.
   always_comb begin
      cmd_in        = cmd_ff;
      stamp_in      = stamp_ff;
      plen_in       = plen_ff;
      dbyte_in      = dbyte_ff;
      limit_in      = limit_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      used_in       = used_ff;
      pkts_in       = pkts_ff;
      fill_in       = fill_ff;
      drop_in       = drop_ff;
      rd_idx_in     = rd_idx_ff;
      wr_idx_in     = wr_idx_ff;
      len_in        = len_ff;
      pstamp_in     = pstamp_ff;
      copy_in       = copy_ff;
      remain_in     = remain_ff;
      res_status_in = res_status_ff;
      res_stamp_in  = res_stamp_ff;
      byte_mode_in  = byte_mode_ff;

      if (dp_cmd.capture) begin
         cmd_in   = cmd_type'(req_command);
         stamp_in = req_stamp;
         plen_in  = req_packet_length;
         dbyte_in = req_data_byte;
         limit_in = req_read_limit;
      end
      // Header admitted: reserve the space and open the packet.
      if (dp_cmd.hdr_accept) begin
         used_in   = used_ff + UW'(HEADER_BYTES) + UW'(plen_ff);
         fill_in   = plen_ff;
         drop_in   = '0;
         wr_idx_in = '0;
         if (plen_ff == '0) pkts_in = pkts_ff + 1'b1;
      end
      if (dp_cmd.hdr_reject) drop_in = plen_ff;
      if (dp_cmd.hdr_wr) begin
         tail_in   = ring_inc(tail_ff);
         wr_idx_in = wr_idx_ff + 1'b1;
      end
      // A data byte either fills the open packet or is swallowed by a drop.
      if (dp_cmd.data_fill) begin
         tail_in = ring_inc(tail_ff);
         fill_in = fill_ff - 1'b1;
         if (fill_ff == LEN_W'(1)) pkts_in = pkts_ff + 1'b1;
      end
      if (dp_cmd.data_drop) drop_in = drop_ff - 1'b1;
      // Header read of the oldest packet.
      if (dp_cmd.rd_start) begin
         rd_idx_in = '0;
         pstamp_in = '0;
      end
      if (dp_cmd.hdr_rd) begin
         if (rd_idx_ff == 3'd0) len_in = rd_len;
         for (int k = 1; k <= STAMP_BYTES; k++) begin
            if (int'(rd_idx_ff) == k) pstamp_in[8*(k-1) +: 8] = rd_data_ff;
         end
         if (!hdr_rd_last) rd_idx_in = rd_idx_ff + 1'b1;
      end
      if (dp_cmd.pay_start) begin
         copy_in      = copy_cur;
         remain_in    = copy_cur;
         byte_mode_in = 1'b1;
      end
      if (dp_cmd.pay_next) remain_in = remain_ff - 1'b1;
      if (dp_cmd.load_res) begin
         res_status_in = dp_cmd.res_status;
         res_stamp_in  = dp_cmd.res_stamp;
         byte_mode_in  = 1'b0;
      end
      // Release the oldest packet.
      if (dp_cmd.free_head) begin
         head_in = ring_add(head_ff, total);
         used_in = (used_ff >= UW'(total)) ? used_ff - UW'(total) : '0;
         pkts_in = pkts_ff - 1'b1;
      end
      if (dp_cmd.clear_all) begin
         head_in = '0;
         tail_in = '0;
         used_in = '0;
         pkts_in = '0;
         fill_in = '0;
         drop_in = '0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         used_ff      <= '0;
         pkts_ff      <= '0;
         fill_ff      <= '0;
         drop_ff      <= '0;
         byte_mode_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         used_ff      <= used_in;
         pkts_ff      <= pkts_in;
         fill_ff      <= fill_in;
         drop_ff      <= drop_in;
         byte_mode_ff <= byte_mode_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      stamp_ff      <= stamp_in;
      plen_ff       <= plen_in;
      dbyte_ff      <= dbyte_in;
      limit_ff      <= limit_in;
      rd_addr_ff    <= rd_addr_in;
      rd_idx_ff     <= rd_idx_in;
      wr_idx_ff     <= wr_idx_in;
      len_ff        <= len_in;
      pstamp_ff     <= pstamp_in;
      copy_ff       <= copy_in;
      remain_ff     <= remain_in;
      res_status_ff <= res_status_in;
      res_stamp_ff  <= res_stamp_in;
   end

   // Byte store with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[tail_ff] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_sel];
   end

   // Status to the controller.
   always_comb begin
      dp_status.cmd         = cmd_ff;
      dp_status.fill_nz     = (fill_ff != '0);
      dp_status.drop_nz     = (drop_ff != '0);
      dp_status.hdr_fits    = hdr_fits;
      dp_status.pkts_nz     = (pkts_ff != '0);
      dp_status.hdr_wr_last = (wr_idx_ff == HW'(HEADER_BYTES - 1));
      dp_status.hdr_rd_last = hdr_rd_last;
      dp_status.copy_zero   = (copy_cur == '0);
      dp_status.pay_last    = (remain_ff == LEN_W'(1));
   end

   // Response fields: a payload byte run, or a single status item.
   always_comb begin
      rsp_status        = byte_mode_ff ? STS_OK : res_status_ff;
      rsp_packet_stamp  = (byte_mode_ff || res_stamp_ff) ? pstamp_ff : '0;
      rsp_payload_byte  = byte_mode_ff ? rd_data_ff : '0;
      rsp_byte_valid    = byte_mode_ff;
      rsp_is_last       = byte_mode_ff ? (remain_ff == LEN_W'(1)) : 1'b1;
      rsp_copied_length = byte_mode_ff ? copy_ff : '0;
   end

endmodule
